FILE: sv/qprelu_pkg.sv
// Shared types and constants of the quantized PReLU block.
package qprelu_pkg;

	localparam int VALUE_W    = 8;
	localparam int CH_W       = 10;
	localparam int SLOPE_W    = 24;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	// Operation carried by an input item
	localparam logic FUNC_SLOPE = 1'b0;
	localparam logic FUNC_DATA  = 1'b1;

	localparam logic LAYOUT_NHWC = 1'b0;
	localparam logic LAYOUT_NCHW = 1'b1;

	// 1.0 in the slope format, used as multiplier on the positive side
	localparam logic [SLOPE_W-1:0] ONE_Q16 = 24'h01_0000;

	localparam logic [31:0] SRC_SCALE_RST     = 32'h0100_0000;
	localparam logic [31:0] DST_INV_SCALE_RST = 32'h0001_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_ZERO,
		CFG_SRC_SCALE,
		CFG_DST_INV_SCALE,
		CFG_DST_ZERO,
		CFG_LAYOUT,
		CFG_CHANNEL_COUNT,
		CFG_SPATIAL_COUNT
	} cfg_index_t;

	typedef struct packed {
		logic [7:0]  src_zero;
		logic [31:0] src_scale;
		logic [31:0] dst_inv_scale;
		logic [7:0]  dst_zero;
		logic        layout;
		logic [10:0] channel_count;
		logic [20:0] spatial_count;
	} qprelu_cfg_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic            last;
	} qprelu_pos_t;

endpackage

FILE: sv/qprelu_if.sv
// Input and output stream interfaces of the quantized PReLU block.
interface qprelu_in_if import qprelu_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [VALUE_W-1:0]        value;
	logic [CH_W-1:0]           slope_addr;
	logic signed [SLOPE_W-1:0] slope_value;

	modport source(output valid, func, value, slope_addr, slope_value, input ready);
	modport sink(input valid, func, value, slope_addr, slope_value, output ready);
endinterface

interface qprelu_out_if import qprelu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] result;
	logic [CH_W-1:0]    channel;
	logic               last;

	modport source(output valid, result, channel, last, input ready);
	modport sink(input valid, result, channel, last, output ready);
endinterface

FILE: sv/qprelu_slope_mem.sv
// Per-channel slope table: one write port, one registered read port.
module qprelu_slope_mem import qprelu_pkg::*; #(
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [SLOPE_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [SLOPE_W-1:0] rd_data
);

	logic [SLOPE_W-1:0] mem_q [DEPTH];
	logic [SLOPE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/qprelu_pos.sv
// Channel and spatial position counters with end-of-tensor flag.
module qprelu_pos import qprelu_pkg::*; #(
	parameter int MAX_CHANNELS = 1024,
	parameter int MAX_SPATIAL  = 1048576,
	localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  qprelu_cfg_t   cfg,
	input  logic          step,
	output qprelu_pos_t   pos,
	output logic [AW-1:0] rd_addr
);

	localparam int CW = $clog2(MAX_CHANNELS + 1);
	localparam int SW = $clog2(MAX_SPATIAL + 1);

	logic [CW-1:0] ch_q, cc, ch_inc;
	logic [SW-1:0] sp_q, sc, sp_inc;
	logic          c_end, s_end, last_w;

	// Limit the counts to 1..max
	always_comb begin
		if (cfg.channel_count == '0) begin
			cc = CW'(1);
		end else if (32'(cfg.channel_count) > 32'(MAX_CHANNELS)) begin
			cc = CW'(MAX_CHANNELS);
		end else begin
			cc = CW'(cfg.channel_count);
		end
		if (cfg.spatial_count == '0) begin
			sc = SW'(1);
		end else if (32'(cfg.spatial_count) > 32'(MAX_SPATIAL)) begin
			sc = SW'(MAX_SPATIAL);
		end else begin
			sc = SW'(cfg.spatial_count);
		end
	end

	assign ch_inc = ch_q + CW'(1);
	assign sp_inc = sp_q + SW'(1);
	assign c_end  = ch_inc >= cc;
	assign s_end  = sp_inc >= sc;
	assign last_w = c_end && s_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
			sp_q <= '0;
		end else if (step) begin
			priority if (last_w) begin
				ch_q <= '0;
				sp_q <= '0;
			end else if (cfg.layout == LAYOUT_NHWC) begin
				if (c_end) begin
					ch_q <= '0;
					sp_q <= sp_inc;
				end else begin
					ch_q <= ch_inc;
				end
			end else begin
				if (s_end) begin
					sp_q <= '0;
					ch_q <= ch_inc;
				end else begin
					sp_q <= sp_inc;
				end
			end
		end
	end

	assign pos.channel = CH_W'(ch_q);
	assign pos.last    = last_w;
	assign rd_addr     = AW'(ch_q);

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_w |=> ch_q == '0 && sp_q == '0)
		else $error("positions not cleared after last item");

	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last_w |=> ch_q != $past(ch_q) || sp_q != $past(sp_q))
		else $error("position did not advance");

endmodule

FILE: sv/qprelu_dp.sv
// Arithmetic pipeline: dequantize, slope, rescale, round and saturate.
module qprelu_dp import qprelu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  qprelu_cfg_t        cfg,
	input  logic               take,
	input  logic [VALUE_W-1:0] value,
	input  qprelu_pos_t        pos,
	input  logic [SLOPE_W-1:0] slope,
	output logic               adv,
	qprelu_out_if.source       dout
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_valid_q;

	logic [7:0]         dmag_s1;
	logic               neg_in_s1;
	qprelu_pos_t        pos_s1, pos_s2, pos_s3, pos_s4, pos_s5, pos_s6;
	logic [39:0]        m_s2;
	logic [SLOPE_W-1:0] smag_s2;
	logic               neg_out_s2, neg_out_s3, neg_out_s4, neg_out_s5, neg_out_s6;
	logic [55:0]        pl_s3;
	logic [31:0]        ph_s3;
	logic [62:0]        m2_s4;
	logic [63:0]        a_s5;
	logic [62:0]        b_s5;
	logic [38:0]        q_s6;
	logic               rnd_s6;
	logic [7:0]         result_q;
	qprelu_pos_t        pos_q;

	logic               neg_in_w;
	logic [7:0]         dmag_w;
	logic               sneg_w;
	logic [SLOPE_W-1:0] smag_w;
	logic [94:0]        full_w;
	logic [39:0]        qr_w;
	logic [8:0]         sum_w;
	logic [7:0]         res_w;

	assign adv = !out_valid_q || dout.ready;

	assign neg_in_w = value < cfg.src_zero;
	assign dmag_w   = neg_in_w ? cfg.src_zero - value : value - cfg.src_zero;

	// Positive side multiplies by 1.0 so both sides share the slope multiplier
	assign sneg_w = slope[SLOPE_W-1];
	assign smag_w = !neg_in_s1 ? ONE_Q16 : (sneg_w ? -slope : slope);

	assign full_w = 95'(a_s5) + {b_s5, 32'b0};

	assign qr_w = 40'(q_s6) + 40'(rnd_s6);

	always_comb begin
		sum_w = 9'(qr_w[7:0]) + 9'(cfg.dst_zero);
		if (neg_out_s6) begin
			res_w = (qr_w >= 40'(cfg.dst_zero)) ? 8'd0 : cfg.dst_zero - qr_w[7:0];
		end else if (qr_w >= 40'd255) begin
			res_w = 8'hFF;
		end else begin
			res_w = sum_w[8] ? 8'hFF : sum_w[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= take;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dmag_s1    <= dmag_w;
			neg_in_s1  <= neg_in_w;
			pos_s1     <= pos;

			m_s2       <= 40'(dmag_s1) * 40'(cfg.src_scale);
			smag_s2    <= smag_w;
			neg_out_s2 <= neg_in_s1 && !sneg_w;
			pos_s2     <= pos_s1;

			pl_s3      <= 56'(m_s2[31:0]) * 56'(smag_s2);
			ph_s3      <= 32'(m_s2[39:32]) * 32'(smag_s2);
			neg_out_s3 <= neg_out_s2;
			pos_s3     <= pos_s2;

			m2_s4      <= 63'({ph_s3, 32'b0} + 64'(pl_s3));
			neg_out_s4 <= neg_out_s3;
			pos_s4     <= pos_s3;

			a_s5       <= 64'(m2_s4[31:0]) * 64'(cfg.dst_inv_scale);
			b_s5       <= 63'(m2_s4[62:32]) * 63'(cfg.dst_inv_scale);
			neg_out_s5 <= neg_out_s4;
			pos_s5     <= pos_s4;

			// Round half to even on the 56 dropped fraction bits
			q_s6       <= full_w[94:56];
			rnd_s6     <= full_w[55] && ((|full_w[54:0]) || full_w[56]);
			neg_out_s6 <= neg_out_s5;
			pos_s6     <= pos_s5;

			result_q   <= res_w;
			pos_q      <= pos_s6;
		end
	end

	assign dout.valid   = out_valid_q;
	assign dout.result  = result_q;
	assign dout.channel = pos_q.channel;
	assign dout.last    = pos_q.last;

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_valid_q}))
		else $error("pipeline moved while stalled");

	a_out_from_s6: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s6))
		else $error("result appeared without an item in the last stage");

	a_s6_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s6 |=> out_valid_q)
		else $error("item lost leaving the last stage");

endmodule

FILE: sv/quantized_prelu_u8.sv
// Quantized PReLU on a uint8 stream with a per-channel slope table. The block
// takes one item per clock cycle when the output side keeps up: a slope write
// goes straight into the slope table in the cycle it is accepted, and a data
// element enters a seven-stage pipeline whose length is set by the chain of
// multipliers (input scale, then slope and output scale, each split into
// products of operands of at most 32 bits) and the final rounding. The slope
// table is one memory with a write port and a registered read port; a slope
// read issued at acceptance always sees every earlier slope write. Slope
// table entries hold no defined value until written, and there is no clearing
// pass after reset. A stalled output holds the whole pipeline and deasserts
// ready.
module quantized_prelu_u8 import qprelu_pkg::*; #(
	parameter int MAX_CHANNELS = 1024,
	parameter int MAX_SPATIAL  = 1048576
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	qprelu_in_if.sink             din,
	qprelu_out_if.source          dout
);

	localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	qprelu_cfg_t        cfg_q;
	qprelu_pos_t        pos;
	logic               adv, accept, take, wr_en;
	logic [AW-1:0]      rd_addr;
	logic [SLOPE_W-1:0] slope;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_zero      <= '0;
			cfg_q.src_scale     <= SRC_SCALE_RST;
			cfg_q.dst_inv_scale <= DST_INV_SCALE_RST;
			cfg_q.dst_zero      <= '0;
			cfg_q.layout        <= LAYOUT_NHWC;
			cfg_q.channel_count <= 11'd1;
			cfg_q.spatial_count <= 21'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SRC_ZERO:      cfg_q.src_zero      <= cfg_data[7:0];
				CFG_SRC_SCALE:     cfg_q.src_scale     <= cfg_data;
				CFG_DST_INV_SCALE: cfg_q.dst_inv_scale <= cfg_data;
				CFG_DST_ZERO:      cfg_q.dst_zero      <= cfg_data[7:0];
				CFG_LAYOUT:        cfg_q.layout        <= cfg_data[0];
				CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[10:0];
				CFG_SPATIAL_COUNT: cfg_q.spatial_count <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	assign din.ready = adv;
	assign accept    = din.valid && adv;
	assign take      = accept && din.func == FUNC_DATA;
	// Drop slope writes beyond the table
	assign wr_en     = accept && din.func == FUNC_SLOPE
		&& 32'(din.slope_addr) < 32'(MAX_CHANNELS);

	qprelu_slope_mem #(
		.DEPTH(MAX_CHANNELS)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(AW'(din.slope_addr)),
		.wr_data(din.slope_value),
		.rd_en  (take),
		.rd_addr(rd_addr),
		.rd_data(slope)
	);

	qprelu_pos #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_SPATIAL (MAX_SPATIAL)
	) u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (take),
		.pos    (pos),
		.rd_addr(rd_addr)
	);

	qprelu_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.take  (take),
		.value (din.value),
		.pos   (pos),
		.slope (slope),
		.adv   (adv),
		.dout  (dout)
	);

endmodule

FILE: dv/quantized_prelu_u8_tb.sv
// Self-checking testbench for the quantized PReLU block with a per-channel slope table.
`timescale 1ns / 1ps

module quantized_prelu_u8_tb import qprelu_pkg::*; ();

	localparam int MAX_CH       = 1024;
	localparam int MAX_SP       = 1048576;
	localparam int RANDOM_ITEMS = 1150;
	localparam int PHASES       = 10;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_LIMIT   = 5000;

	typedef struct {
		logic                      func;
		logic [VALUE_W-1:0]        value;
		logic [CH_W-1:0]           slope_addr;
		logic signed [SLOPE_W-1:0] slope_value;
	} prelu_in_t;

	typedef struct {
		logic [VALUE_W-1:0] result;
		logic [CH_W-1:0]    channel;
		logic               last;
	} prelu_out_t;

	class prelu_tracker;
		logic [7:0]         src_zero;
		logic [31:0]        src_scale;
		logic [31:0]        dst_inv_scale;
		logic [7:0]         dst_zero;
		logic               layout;
		logic [10:0]        channel_count;
		logic [20:0]        spatial_count;
		logic [SLOPE_W-1:0] slope_mem [MAX_CH];
		bit                 slope_known [MAX_CH];
		logic [CH_W-1:0]    channel_pos;
		logic [19:0]        spatial_pos;
		prelu_out_t         pending_outputs [$];
		int                 errors;

		function new();
			src_zero      = 8'd0;
			src_scale     = SRC_SCALE_RST;
			dst_inv_scale = DST_INV_SCALE_RST;
			dst_zero      = 8'd0;
			layout        = LAYOUT_NHWC;
			channel_count = 11'd1;
			spatial_count = 21'd1;
			channel_pos   = '0;
			spatial_pos   = '0;
			errors        = 0;
			foreach (slope_known[i]) slope_known[i] = 1'b0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_SRC_ZERO:      src_zero      = data[7:0];
				CFG_SRC_SCALE:     src_scale     = data;
				CFG_DST_INV_SCALE: dst_inv_scale = data;
				CFG_DST_ZERO:      dst_zero      = data[7:0];
				CFG_LAYOUT:        layout        = data[0];
				CFG_CHANNEL_COUNT: channel_count = data[10:0];
				CFG_SPATIAL_COUNT: spatial_count = data[20:0];
				default: ;
			endcase
		endfunction

		// Full-precision requantization of one element, then advance the positions.
		function prelu_out_t quantize_element(logic [7:0] v);
			prelu_out_t   o;
			logic         neg_in, sneg, neg_out, c_end, s_end;
			logic [7:0]   dmag;
			logic [39:0]  scaled_in;
			logic [62:0]  mag;
			logic [23:0]  raw, smag;
			logic [94:0]  prod;
			logic [39:0]  q;
			logic [55:0]  frac;
			logic [8:0]   sum;
			int unsigned  cc, sc;
			cc = (channel_count == 0) ? 1 : (channel_count > MAX_CH ? MAX_CH : channel_count);
			sc = (spatial_count == 0) ? 1 : (spatial_count > MAX_SP ? MAX_SP : spatial_count);
			neg_in = v < src_zero;
			dmag = neg_in ? src_zero - v : v - src_zero;
			scaled_in = 40'(dmag) * 40'(src_scale);
			if (!neg_in) begin
				mag = {7'b0, scaled_in, 16'b0};
				neg_out = 1'b0;
			end else begin
				raw = slope_mem[channel_pos];
				sneg = raw[23];
				smag = sneg ? (~raw + 24'd1) : raw;
				mag = 63'(scaled_in) * 63'(smag);
				neg_out = !sneg;
			end
			prod = 95'(mag) * 95'(dst_inv_scale);
			q = {1'b0, prod[94:56]};
			frac = prod[55:0];
			// round half to even on the 56 dropped fraction bits
			if (frac > {1'b1, 55'b0} || (frac == {1'b1, 55'b0} && q[0]))
				q = q + 40'd1;
			if (neg_out) begin
				o.result = (q >= 40'(dst_zero)) ? 8'd0 : dst_zero - q[7:0];
			end else if (q >= 40'd255) begin
				o.result = 8'hFF;
			end else begin
				sum = 9'(q[7:0]) + 9'(dst_zero);
				o.result = (sum > 9'd255) ? 8'hFF : sum[7:0];
			end
			o.channel = channel_pos;
			c_end = 32'(channel_pos) + 32'd1 >= cc;
			s_end = 32'(spatial_pos) + 32'd1 >= sc;
			o.last = c_end && s_end;
			if (o.last) begin
				channel_pos = '0;
				spatial_pos = '0;
			end else if (layout == LAYOUT_NHWC) begin
				if (c_end) begin
					channel_pos = '0;
					spatial_pos = spatial_pos + 20'd1;
				end else begin
					channel_pos = channel_pos + 10'd1;
				end
			end else begin
				if (s_end) begin
					spatial_pos = '0;
					channel_pos = channel_pos + 10'd1;
				end else begin
					spatial_pos = spatial_pos + 20'd1;
				end
			end
			return o;
		endfunction

		function void note_item(prelu_in_t it);
			if (it.func == FUNC_SLOPE) begin
				slope_mem[it.slope_addr] = it.slope_value;
				slope_known[it.slope_addr] = 1'b1;
			end else begin
				pending_outputs.push_back(quantize_element(it.value));
			end
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(prelu_out_t got);
			prelu_out_t want;
			if (pending_outputs.size() == 0) begin
				report($sformatf("unexpected item: result %0d channel %0d last %0b",
					got.result, got.channel, got.last));
				return;
			end
			want = pending_outputs.pop_front();
			if (got.result !== want.result)
				report($sformatf("result %0d, expected %0d (channel %0d)",
					got.result, want.result, want.channel));
			if (got.channel !== want.channel)
				report($sformatf("channel %0d, expected %0d", got.channel, want.channel));
			if (got.last !== want.last)
				report($sformatf("last %0b, expected %0b (channel %0d)",
					got.last, want.last, want.channel));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    quiet_cycles = 0;
	bit                    in_steady = 1'b0;
	bit                    out_steady = 1'b0;
	prelu_tracker          tracker = new();

	qprelu_in_if  din_if();
	qprelu_out_if dout_if();

	quantized_prelu_u8 i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.din       (din_if),
		.dout      (dout_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		tracker.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setup(logic [7:0] sz, logic [31:0] ss, logic [31:0] dis,
			logic [7:0] dz, logic lay, logic [10:0] cc, logic [20:0] sc);
		write_reg(CFG_SRC_ZERO, 32'(sz));
		write_reg(CFG_SRC_SCALE, ss);
		write_reg(CFG_DST_INV_SCALE, dis);
		write_reg(CFG_DST_ZERO, 32'(dz));
		write_reg(CFG_LAYOUT, 32'(lay));
		write_reg(CFG_CHANNEL_COUNT, 32'(cc));
		write_reg(CFG_SPATIAL_COUNT, 32'(sc));
	endtask

	// Drop valid, drain every expected result, then let the pipeline empty.
	task automatic settle();
		@(negedge clk);
		din_if.valid <= 1'b0;
		while (tracker.pending_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_item(prelu_in_t it);
		int gap;
		if ($urandom_range(0, 49) == 0) in_steady = !in_steady;
		gap = in_steady ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			din_if.valid <= 1'b0;
		end
		@(negedge clk);
		din_if.valid       <= 1'b1;
		din_if.func        <= it.func;
		din_if.value       <= it.value;
		din_if.slope_addr  <= it.slope_addr;
		din_if.slope_value <= it.slope_value;
		@(posedge clk);
		while (!din_if.ready) @(posedge clk);
		tracker.note_item(it);
	endtask

	function automatic logic [SLOPE_W-1:0] draw_slope();
		logic [SLOPE_W-1:0] s;
		case ($urandom_range(0, 3))
			0: s = SLOPE_W'($urandom);
			1: s = SLOPE_W'($urandom_range(0, 1 << 17));
			2: s = -SLOPE_W'($urandom_range(0, 1 << 17));
			default: s = ONE_Q16;
		endcase
		return s;
	endfunction

	task automatic send_slope(logic [CH_W-1:0] addr, logic [SLOPE_W-1:0] slope);
		prelu_in_t it;
		it.func        = FUNC_SLOPE;
		it.value       = VALUE_W'($urandom);
		it.slope_addr  = addr;
		it.slope_value = slope;
		push_item(it);
	endtask

	// Load a slope first if a negative element would read an unwritten entry.
	task automatic send_element(logic [7:0] v);
		prelu_in_t it;
		if (v < tracker.src_zero && !tracker.slope_known[tracker.channel_pos])
			send_slope(tracker.channel_pos, draw_slope());
		it.func        = FUNC_DATA;
		it.value       = v;
		it.slope_addr  = CH_W'($urandom);
		it.slope_value = SLOPE_W'($urandom);
		push_item(it);
	endtask

	function automatic logic [31:0] draw_scale(logic [31:0] unity);
		logic [31:0] s;
		case ($urandom_range(0, 7))
			0: s = 32'd0;
			1: s = 32'hFFFF_FFFF;
			2: s = $urandom;
			default: s = $urandom_range(unity >> 2, unity << 2);
		endcase
		return s;
	endfunction

	function automatic logic [7:0] draw_zero();
		logic [7:0] z;
		case ($urandom_range(0, 3))
			0: z = 8'd0;
			1: z = 8'd255;
			default: z = 8'($urandom);
		endcase
		return z;
	endfunction

	// Output side: stall a random number of cycles ahead of each item.
	initial begin
		int stall;
		dout_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 49) == 0) out_steady = !out_steady;
			stall = out_steady ? 0 : $urandom_range(0, 10);
			repeat (stall) begin
				@(negedge clk);
				dout_if.ready <= 1'b0;
			end
			@(negedge clk);
			dout_if.ready <= 1'b1;
			@(posedge clk);
			while (!dout_if.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		prelu_out_t got;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			got.result  = dout_if.result;
			got.channel = dout_if.channel;
			got.last    = dout_if.last;
			tracker.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("quantized_prelu_u8 test failed");
				$finish;
			end
		end
	end

	initial begin
		logic [10:0] cc;
		logic [20:0] sc;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = CFG_SRC_ZERO;
		cfg_data           = '0;
		din_if.valid       = 1'b0;
		din_if.func        = FUNC_DATA;
		din_if.value       = '0;
		din_if.slope_addr  = '0;
		din_if.slope_value = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Scale by one half so odd offsets land on rounding ties.
		apply_setup(8'd128, 32'h0100_0000, 32'h0000_8000, 8'd128, LAYOUT_NHWC, 11'd2, 21'd2);
		send_slope(10'd0, ONE_Q16);
		send_slope(10'd1, 24'h80_0000);
		send_slope(10'd1023, 24'h7F_FFFF);
		send_element(8'd129);
		send_element(8'd131);
		send_element(8'd127);
		send_element(8'd0);
		send_element(8'd255);
		send_slope(10'd1, 24'h00_0000);
		send_element(8'd0);
		settle();

		// Largest scales; spatial position now sits beyond the shrunken count.
		apply_setup(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, LAYOUT_NCHW, 11'd8, 21'd1);
		send_element(8'd0);
		send_element(8'd255);
		send_element(8'd254);
		send_element(8'd128);
		settle();

		// Zero counts act as one; channel position is beyond the last index.
		apply_setup(8'd0, 32'h0100_0000, 32'h0001_0000, 8'd255, LAYOUT_NHWC, 11'd0, 21'd0);
		send_element(8'd255);
		send_element(8'd0);
		send_element(8'd1);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) begin
				apply_setup(8'd255, 32'd0, 32'hFFFF_FFFF, 8'd255, LAYOUT_NCHW, 11'd1024,
					21'd1048576);
			end else if (phase == 1) begin
				apply_setup(8'd0, 32'hFFFF_FFFF, 32'd0, 8'd0, LAYOUT_NHWC, 11'h7FF, 21'h1F_FFFF);
			end else begin
				case ($urandom_range(0, 9))
					0: cc = 11'd0;
					1: cc = 11'd1024;
					2: cc = 11'h7FF;
					3: cc = 11'($urandom);
					default: cc = 11'($urandom_range(1, 8));
				endcase
				case ($urandom_range(0, 9))
					0: sc = 21'd0;
					1: sc = 21'd1048576;
					2: sc = 21'h1F_FFFF;
					3: sc = 21'($urandom);
					default: sc = 21'($urandom_range(1, 6));
				endcase
				apply_setup(draw_zero(), draw_scale(32'h0100_0000), draw_scale(32'h0001_0000),
					draw_zero(), $urandom_range(0, 1) ? LAYOUT_NCHW : LAYOUT_NHWC, cc, sc);
			end
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				if ($urandom_range(0, 4) == 0)
					send_slope($urandom_range(0, 1) ? CH_W'($urandom) : tracker.channel_pos,
						draw_slope());
				else
					send_element(8'($urandom));
			end
			settle();
		end

		if (tracker.errors == 0 && tracker.pending_outputs.size() == 0)
			$display("quantized_prelu_u8 test passed");
		else
			$display("quantized_prelu_u8 test failed");
		$finish;
	end

endmodule

FILE: files.f
sv/qprelu_pkg.sv
sv/qprelu_if.sv
sv/qprelu_slope_mem.sv
sv/qprelu_pos.sv
sv/qprelu_dp.sv
sv/quantized_prelu_u8.sv
dv/quantized_prelu_u8_tb.sv
